// File: src/bts_pkg.sv
// Shared constants and types for the bilinear texture sampler.
// No dependencies.
package bts_pkg;
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int XW          = $clog2(MAX_WIDTH);
    localparam int YW          = $clog2(MAX_HEIGHT);
    localparam int DIM_W       = 9;
    localparam int COORD_W     = 18;
    localparam int UC_W        = 17;
    localparam int TEXEL_W     = 24;
    localparam int WGT_W       = 33;
    localparam int PROD_W      = WGT_W + 8;
    localparam int ACC_W       = PROD_W + 2;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef logic [TEXEL_W-1:0] t_texel;
endpackage

// File: src/bilinear_texture_sampler_unit.sv
// Bilinear texture sampler: pipelined clamp/scale, four-corner fetch, blend.
// Uses bts_pkg and two copies of the texel store in bts_ram.
// Result strobe o_done is registered at the end of the last stage.
// Throughput: one item per cycle, set by the 6-stage pipeline; busy is always low.
// Writes travel the pipeline and hit the store in the same stage as sample
// reads, so items see the store in order. Reset: synchronous, active low;
// registers reset to 256x256; the texel store is not cleared.
module bilinear_texture_sampler_unit
    import bts_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_action,
    input  logic [15:0]               i_texel_index,
    input  logic [7:0]                i_texel_red,
    input  logic [7:0]                i_texel_green,
    input  logic [7:0]                i_texel_blue,
    input  logic signed [COORD_W-1:0] i_u_coord,
    input  logic signed [COORD_W-1:0] i_v_coord,
    output logic                      o_done,
    output logic [15:0]               o_red_out,
    output logic [15:0]               o_green_out,
    output logic [15:0]               o_blue_out,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    logic [DIM_W-1:0] r_tex_width, r_tex_height;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [XW-1:0]    wm1;
    logic [YW-1:0]    hm1;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {23'd0, r_tex_height} : {23'd0, r_tex_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= DIM_W'(MAX_WIDTH);
            r_tex_height <= DIM_W'(MAX_HEIGHT);
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_WIDTH) begin
                r_tex_width <= pwdata[DIM_W-1:0];
            end else begin
                r_tex_height <= pwdata[DIM_W-1:0];
            end
        end
    end

    always_comb begin
        w_eff = (r_tex_width == '0) ? DIM_W'(1)
              : (r_tex_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_tex_width;
        h_eff = (r_tex_height == '0) ? DIM_W'(1)
              : (r_tex_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : r_tex_height;
        wm1 = XW'(w_eff - DIM_W'(1));
        hm1 = YW'(h_eff - DIM_W'(1));
    end

    // stage 0: capture
    logic                      r0_v, r0_act;
    logic [15:0]               r0_idx;
    t_texel                    r0_tx;
    logic signed [COORD_W-1:0] r0_u, r0_v_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_v <= 1'b0;
        else          r0_v <= start;
        r0_act <= i_action;
        r0_idx <= i_texel_index;
        r0_tx  <= {i_texel_red, i_texel_green, i_texel_blue};
        r0_u   <= i_u_coord;
        r0_v_c <= i_v_coord;
    end

    // stage 1: clamp and scale
    logic [UC_W-1:0]    uc, vc;
    logic               r1_v, r1_act;
    logic [15:0]        r1_idx;
    t_texel             r1_tx;
    logic [UC_W+XW-1:0] r1_px;
    logic [UC_W+YW-1:0] r1_py;

    always_comb begin
        uc = r0_u[COORD_W-1] ? '0 : (r0_u[COORD_W-2:0] > 17'h10000) ? 17'h10000 : r0_u[UC_W-1:0];
        vc = r0_v_c[COORD_W-1] ? '0
           : (r0_v_c[COORD_W-2:0] > 17'h10000) ? 17'h10000 : r0_v_c[UC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= r0_v;
        r1_act <= r0_act;
        r1_idx <= r0_idx;
        r1_tx  <= r0_tx;
        r1_px  <= uc * wm1;
        r1_py  <= vc * hm1;
    end

    // stage 2: corners, fractions, addresses
    logic [XW-1:0]     x0, x1;
    logic [YW-1:0]     y0, y1;
    logic [ADDR_W-1:0] row0, row1;
    logic              r2_v, r2_act;
    logic [ADDR_W-1:0] r2_widx;
    t_texel            r2_tx;
    logic [ADDR_W-1:0] r2_a00, r2_a01, r2_a10, r2_a11;
    logic [15:0]       r2_fx, r2_fy;

    always_comb begin
        x0 = r1_px[16 +: XW];
        y0 = r1_py[16 +: YW];
        x1 = ({1'b0, x0} + DIM_W'(1) < w_eff) ? XW'(x0 + XW'(1)) : wm1;
        y1 = ({1'b0, y0} + DIM_W'(1) < h_eff) ? YW'(y0 + YW'(1)) : hm1;
        row0 = ADDR_W'(y0 * w_eff);
        row1 = ADDR_W'(y1 * w_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_act  <= r1_act;
        r2_widx <= r1_idx[ADDR_W-1:0];
        r2_tx   <= r1_tx;
        r2_a00  <= row0 + ADDR_W'(x0);
        r2_a01  <= row1 + ADDR_W'(x0);
        r2_a10  <= row0 + ADDR_W'(x1);
        r2_a11  <= row1 + ADDR_W'(x1);
        r2_fx   <= r1_px[15:0];
        r2_fy   <= r1_py[15:0];
    end

    // stage 3: store access (writes land here too) and weights
    logic   st_we;
    t_texel c00, c01, c10, c11;
    logic   r3_v;
    logic [UC_W-1:0]  ifx, ify;
    logic [WGT_W-1:0] r3_w00, r3_w01, r3_w10, r3_w11;

    assign st_we = r2_v && (r2_act == ACT_WRITE);

    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_store_a (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(r2_widx), .i_wdata(r2_tx),
        .i_raddr_a(r2_a00), .i_raddr_b(r2_a01), .o_rdata_a(c00), .o_rdata_b(c01)
    );

    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_store_b (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(r2_widx), .i_wdata(r2_tx),
        .i_raddr_a(r2_a10), .i_raddr_b(r2_a11), .o_rdata_a(c10), .o_rdata_b(c11)
    );

    always_comb begin
        ifx = 17'h10000 - UC_W'(r2_fx);
        ify = 17'h10000 - UC_W'(r2_fy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v && (r2_act == ACT_SAMPLE);
        r3_w00 <= WGT_W'(ifx * ify);
        r3_w01 <= WGT_W'(ifx * UC_W'(r2_fy));
        r3_w10 <= WGT_W'(UC_W'(r2_fx) * ify);
        r3_w11 <= WGT_W'(r2_fx * r2_fy);
    end

    // stage 4: per-channel products
    logic              r4_v;
    logic [PROD_W-1:0] r4_p [3][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
        for (int ch = 0; ch < 3; ch++) begin
            r4_p[ch][0] <= r3_w00 * c00[16-8*ch +: 8];
            r4_p[ch][1] <= r3_w01 * c01[16-8*ch +: 8];
            r4_p[ch][2] <= r3_w10 * c10[16-8*ch +: 8];
            r4_p[ch][3] <= r3_w11 * c11[16-8*ch +: 8];
        end
    end

    // stage 5: sum, round half up
    logic [ACC_W-1:0] acc [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            acc[ch] = ACC_W'(r4_p[ch][0]) + ACC_W'(r4_p[ch][1]) + ACC_W'(r4_p[ch][2])
                    + ACC_W'(r4_p[ch][3]) + (ACC_W'(1) << 23);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else          o_done <= r4_v;
        o_red_out   <= acc[0][24 +: 16];
        o_green_out <= acc[1][24 +: 16];
        o_blue_out  <= acc[2][24 +: 16];
    end
endmodule

// File: src/bts_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module bts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// File: test/tb.sv
// Testbench for bilinear_texture_sampler_unit: random and directed texel writes and
// bilinear samples over several texture sizes, checked against an in-bench predictor.
// Depends on bts_pkg and the sampler RTL.
`timescale 1ns / 1ps

typedef struct {
    bit [15:0] red;
    bit [15:0] green;
    bit [15:0] blue;
} rgb_result_t;

class texel_scoreboard;
    bit [23:0]   texels [int];
    int unsigned width_reg;
    int unsigned height_reg;
    rgb_result_t expected_rgb [$];
    int          errors;
    int          n_samples;
    int          n_writes;

    function new();
        width_reg  = 256;
        height_reg = 256;
    endfunction

    function void set_dim(bit is_height, bit [8:0] val);
        if (is_height) height_reg = val;
        else width_reg = val;
    endfunction

    function int unsigned clamp_q16(bit signed [17:0] c);
        if (c < 0) return 0;
        if (c > 65536) return 65536;
        return c;
    endfunction

    function int unsigned fetch(int unsigned addr);
        if (texels.exists(addr)) return texels[addr];
        return 0;
    endfunction

    // note one accepted item; samples push the blended color
    function void note_item(bit act, bit [15:0] idx, bit [7:0] r, bit [7:0] g,
                            bit [7:0] b, bit signed [17:0] u, bit signed [17:0] v);
        int unsigned w, h, px, py, x0, y0, x1, y1, fx, fy;
        int unsigned c00, c01, c10, c11, sh;
        longint unsigned w00, w01, w10, w11, acc;
        bit [15:0] chan [3];
        rgb_result_t res;
        if (act == bts_pkg::ACT_WRITE) begin
            texels[idx] = {r, g, b};
            n_writes++;
            return;
        end
        w = (width_reg < 1) ? 1 : (width_reg > 256) ? 256 : width_reg;
        h = (height_reg < 1) ? 1 : (height_reg > 256) ? 256 : height_reg;
        px = clamp_q16(u) * (w - 1);
        py = clamp_q16(v) * (h - 1);
        x0 = px >> 16;
        y0 = py >> 16;
        fx = px & 16'hFFFF;
        fy = py & 16'hFFFF;
        x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
        y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
        w00 = longint'(65536 - fx) * (65536 - fy);
        w01 = longint'(65536 - fx) * fy;
        w10 = longint'(fx) * (65536 - fy);
        w11 = longint'(fx) * fy;
        c00 = fetch(y0 * w + x0);
        c01 = fetch(y1 * w + x0);
        c10 = fetch(y0 * w + x1);
        c11 = fetch(y1 * w + x1);
        for (int ch = 0; ch < 3; ch++) begin
            sh = 16 - 8 * ch;
            acc = w00 * ((c00 >> sh) & 8'hFF) + w01 * ((c01 >> sh) & 8'hFF)
                + w10 * ((c10 >> sh) & 8'hFF) + w11 * ((c11 >> sh) & 8'hFF);
            chan[ch] = 16'((acc + (64'd1 << 23)) >> 24);
        end
        res.red   = chan[0];
        res.green = chan[1];
        res.blue  = chan[2];
        expected_rgb.push_back(res);
        n_samples++;
    endfunction

    function void check_result(bit [15:0] r, bit [15:0] g, bit [15:0] b);
        rgb_result_t e;
        if (expected_rgb.size() == 0) begin
            $display("%0t: unexpected result r=%h g=%h b=%h", $time, r, g, b);
            errors++;
            return;
        end
        e = expected_rgb.pop_front();
        if (e.red !== r) begin
            $display("%0t: red mismatch exp=%h act=%h", $time, e.red, r);
            errors++;
        end
        if (e.green !== g) begin
            $display("%0t: green mismatch exp=%h act=%h", $time, e.green, g);
            errors++;
        end
        if (e.blue !== b) begin
            $display("%0t: blue mismatch exp=%h act=%h", $time, e.blue, b);
            errors++;
        end
    endfunction
endclass

module tb;
    import bts_pkg::*;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_action;
    logic [15:0]               i_texel_index;
    logic [7:0]                i_texel_red;
    logic [7:0]                i_texel_green;
    logic [7:0]                i_texel_blue;
    logic signed [COORD_W-1:0] i_u_coord;
    logic signed [COORD_W-1:0] i_v_coord;
    logic                      o_done;
    logic [15:0]               o_red_out;
    logic [15:0]               o_green_out;
    logic [15:0]               o_blue_out;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [2:0]                paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;

    texel_scoreboard sb = new();
    int idle_cycles;
    localparam int STALL_LIMIT = 5000;
    // every texture size used keeps width*height within this many texels
    localparam int FILL_DEPTH  = 256;

    bilinear_texture_sampler_unit uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_item(i_action, i_texel_index, i_texel_red, i_texel_green,
                         i_texel_blue, i_u_coord, i_v_coord);
        if (i_rst_n && o_done)
            sb.check_result(o_red_out, o_green_out, o_blue_out);
        if ((i_rst_n && start && !busy) || o_done || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // present one item and hold it until the block takes it
    task automatic send_item(bit act, bit [15:0] idx, bit [23:0] rgb,
                             bit [17:0] u, bit [17:0] v, bit gaps);
        bit taken;
        int unsigned g;
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= act;
        i_texel_index <= idx;
        {i_texel_red, i_texel_green, i_texel_blue} <= rgb;
        i_u_coord     <= u;
        i_v_coord     <= v;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
    endtask

    task automatic write_texel(bit [15:0] idx, bit [23:0] rgb, bit gaps);
        send_item(ACT_WRITE, idx, rgb, 18'($urandom), 18'($urandom), gaps);
    endtask

    task automatic sample_at(bit [17:0] u, bit [17:0] v);
        send_item(ACT_SAMPLE, 16'($urandom), 24'($urandom), u, v, 1'b1);
    endtask

    // let every pending result drain, plus the pipeline depth for writes
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_rgb.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic apb_write(bit is_height, bit [8:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= is_height ? 3'd4 : 3'd0;
        pwdata  <= {23'($urandom_range(0, 8388607)), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_dim(is_height, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function bit [17:0] rand_coord();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 75) return 18'($urandom_range(0, 65536));
        if (p < 85) return $urandom_range(0, 3) == 0 ? 18'd65536 : 18'd0;
        return 18'($urandom);
    endfunction

    initial begin
        bit [8:0] dims [8][2];
        dims = '{'{9'd256, 9'd1}, '{9'd1, 9'd256}, '{9'd0, 9'd0}, '{9'd511, 9'd1},
                 '{9'd1, 9'd257}, '{9'd2, 9'd3}, '{9'd3, 9'd60}, '{9'd0, 9'd0}};
        dims[7][0] = 9'($urandom_range(1, 16));
        dims[7][1] = 9'($urandom_range(1, 16));
        idle_cycles   = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_action      = ACT_WRITE;
        i_texel_index = '0;
        i_texel_red   = '0;
        i_texel_green = '0;
        i_texel_blue  = '0;
        i_u_coord     = '0;
        i_v_coord     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 16x16 texture for the directed part
        apb_write(1'b0, 9'd16);
        apb_write(1'b1, 9'd16);

        // fill the texels that any sample can reach
        for (int a = 0; a < FILL_DEPTH; a++) write_texel(16'(a), 24'($urandom), 1'b0);

        // directed: extreme bytes and addresses, coordinate clamps
        write_texel(16'h0000, 24'h000000, 1'b1);
        write_texel(16'hFFFF, 24'hFFFFFF, 1'b1);
        write_texel(16'h0001, 24'hFF00FF, 1'b1);
        write_texel(16'h0010, 24'h00FF00, 1'b1);
        write_texel(16'h0011, 24'hA5_5A_C3, 1'b1);
        sample_at(18'h20000, 18'h20000);
        sample_at(18'h1FFFF, 18'h1FFFF);
        sample_at(18'd0, 18'd0);
        sample_at(18'd65536, 18'd65536);
        sample_at(18'd65535, 18'd65535);
        sample_at(18'd32768, 18'd0);
        sample_at(18'd0, 18'd32768);
        sample_at(18'd257, 18'd300);
        sample_at(18'h3FFFF, 18'd65537);
        sample_at(18'd65536, 18'h20000);

        foreach (dims[ph]) begin
            drain();
            apb_write(1'b0, dims[ph][0]);
            apb_write(1'b1, dims[ph][1]);
            for (int n = 0; n < 220; n++) begin
                if ($urandom_range(0, 99) < 35)
                    write_texel($urandom_range(0, 5) == 0 ? 16'($urandom) :
                                16'($urandom_range(0, FILL_DEPTH - 1)),
                                24'($urandom), 1'b1);
                else
                    sample_at(rand_coord(), rand_coord());
            end
        end

        drain();
        $display("Covered %0d texel writes and %0d samples over %0d texture sizes.",
                 sb.n_writes, sb.n_samples, 9);
        if (sb.errors == 0 && sb.expected_rgb.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
